>>> hdl/atapr_pkg.sv
// ----------------------------------------------------------------------------
// atapr_pkg
// Shared types and constants for the ATA PIO byte range read sequencer.
// ----------------------------------------------------------------------------
package atapr_pkg;

  // Sector geometry
  localparam int SECTOR_BYTE_BITS = 9;    // 512 bytes per sector
  localparam int SECTOR_WORD_BITS = 8;    // 256 words per sector
  localparam int MAX_SECTORS      = 255;

  // Results per input item, and the width of a count of them
  localparam int MAX_RESULTS = 7;
  localparam int RES_CNT_W   = 3;

  // Request codes on the input channel
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_STATUS = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;

  // Taskfile register offsets
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_DRIVE   = 3'd6;
  localparam logic [2:0] REG_CMD     = 3'd7;

  // Taskfile values
  localparam logic [7:0] DRIVE_LBA_SEL = 8'hE0;
  localparam logic [3:0] LBA_TOP_MASK  = 4'hF;
  localparam logic [7:0] CMD_READ_PIO  = 8'h20;

  // Status register bits
  localparam int ST_BSY = 7;
  localparam int ST_DF  = 5;
  localparam int ST_ERR = 0;

  typedef enum logic [2:0] {
    ACT_REGW = 3'd0,
    ACT_STAT = 3'd1,
    ACT_DATA = 3'd2,
    ACT_BYTE = 3'd3,
    ACT_DONE = 3'd4,
    ACT_ERR  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_POLL = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    action_t    action;
    logic [2:0] reg_offset;
    logic [7:0] value;
    logic       last;
  } result_t;

  function automatic result_t mk_result(action_t act, logic [2:0] ofs, logic [7:0] val);
    result_t r;
    r.action     = act;
    r.reg_offset = ofs;
    r.value      = val;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

>>> hdl/ata_pio_byte_range_read_core.sv
// Latency: the first result of an input beat is offered on the cycle after acceptance.
// Throughput: one input beat per cycle while out_ready is high and each beat yields at most
// one result; a beat with more results holds the input until its last one is taken (a start
// request in idle with a valid span gives 7). A beat with no result is taken and dropped.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the result queue.
// ----------------------------------------------------------------------------
// ata_pio_byte_range_read_core
// Host-side ATA PIO LBA28 sequencer that reads a byte range spanning at most 255 sectors.
// ----------------------------------------------------------------------------
module ata_pio_byte_range_read_core
  import atapr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_byte_address,
  input  logic [16:0] in_byte_length,
  input  logic [7:0]  in_status_value,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [2:0]  out_reg_offset,
  output logic [7:0]  out_value,
  output logic        out_run_last
);

  result_t              res [MAX_RESULTS];
  logic [RES_CNT_W-1:0] res_cnt;
  result_t              queue_r [MAX_RESULTS];
  result_t              queue_nxt [MAX_RESULTS];
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 in_fire, out_fire;

  // Take a new beat when the queue is empty or its last entry leaves now
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || (cnt_r == 3'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;

  atapr_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .req_type     (in_req_type),
    .byte_address (in_byte_address),
    .byte_length  (in_byte_length),
    .status_value (in_status_value),
    .data_word    (in_data_word),
    .res          (res),
    .res_cnt      (res_cnt)
  );

  // Load a fresh result list, or shift out the head
  always_comb begin
    queue_nxt = queue_r;
    cnt_nxt   = cnt_r;
    if (in_fire) begin
      queue_nxt = res;
      cnt_nxt   = res_cnt;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        queue_nxt[i] = queue_r[i + 1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  // Hold the queue payload
  always_ff @(posedge clk) begin
    queue_r <= queue_nxt;
  end

  // Hold the queue fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Present the head of the queue
  assign out_action     = queue_r[0].action;
  assign out_reg_offset = queue_r[0].reg_offset;
  assign out_value      = queue_r[0].value;
  assign out_run_last   = queue_r[0].last;

endmodule

>>> hdl/atapr_step.sv
// ----------------------------------------------------------------------------
// atapr_step
// Sequencer state and the decode of one input beat into its result list.
// ----------------------------------------------------------------------------
module atapr_step
  import atapr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [1:0]           req_type,
  input  logic [31:0]          byte_address,
  input  logic [16:0]          byte_length,
  input  logic [7:0]           status_value,
  input  logic [15:0]          data_word,
  output result_t              res [MAX_RESULTS],
  output logic [RES_CNT_W-1:0] res_cnt
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic        odd_r, odd_nxt;
  logic [16:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] word_index_r, word_index_nxt;
  logic [15:0] total_words_r, total_words_nxt;

  // Range arithmetic for a start request
  logic [32:0] last_addr;
  logic [27:0] first_sec;
  logic [23:0] last_sec;
  logic [23:0] sec_count;
  logic [15:0] wi_inc;

  assign last_addr = {1'b0, byte_address} + {16'd0, byte_length} - 33'd1;
  assign first_sec = {5'd0, byte_address[31:SECTOR_BYTE_BITS]};
  assign last_sec  = last_addr[32:SECTOR_BYTE_BITS];
  assign sec_count = last_sec - first_sec[23:0] + 24'd1;
  assign wi_inc    = word_index_r + 16'd1;

  // Decode the beat and build its results
  always_comb begin
    logic [RES_CNT_W-1:0] n;
    n               = '0;
    phase_nxt       = phase_r;
    skip_nxt        = skip_r;
    odd_nxt         = odd_r;
    bytes_left_nxt  = bytes_left_r;
    word_index_nxt  = word_index_r;
    total_words_nxt = total_words_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    case (phase_r)
      PH_IDLE: begin
        if (req_type == REQ_START) begin
          if (byte_length == '0 || sec_count > 24'(MAX_SECTORS)) begin
            res[0] = mk_result(ACT_ERR, REG_DATA, 8'd0);
            n      = 3'd1;
          end else begin
            skip_nxt        = byte_address[SECTOR_BYTE_BITS-1:1];
            odd_nxt         = byte_address[0];
            bytes_left_nxt  = byte_length;
            word_index_nxt  = '0;
            total_words_nxt = {sec_count[7:0], {SECTOR_WORD_BITS{1'b0}}};
            res[0] = mk_result(ACT_REGW, REG_DRIVE,
                               DRIVE_LBA_SEL | {4'd0, first_sec[27:24] & LBA_TOP_MASK});
            res[1] = mk_result(ACT_REGW, REG_COUNT, sec_count[7:0]);
            res[2] = mk_result(ACT_REGW, REG_LBA_LO, first_sec[7:0]);
            res[3] = mk_result(ACT_REGW, REG_LBA_MID, first_sec[15:8]);
            res[4] = mk_result(ACT_REGW, REG_LBA_HI, first_sec[23:16]);
            res[5] = mk_result(ACT_REGW, REG_CMD, CMD_READ_PIO);
            res[6] = mk_result(ACT_STAT, REG_CMD, 8'd0);
            n         = 3'd7;
            phase_nxt = PH_POLL;
          end
        end
      end

      PH_POLL: begin
        if (req_type == REQ_STATUS) begin
          if (status_value[ST_DF] || status_value[ST_ERR]) begin
            res[0]    = mk_result(ACT_ERR, REG_DATA, 8'd0);
            phase_nxt = PH_IDLE;
          end else if (status_value[ST_BSY]) begin
            res[0]    = mk_result(ACT_STAT, REG_CMD, 8'd0);
          end else begin
            res[0]    = mk_result(ACT_DATA, REG_DATA, 8'd0);
            phase_nxt = PH_DATA;
          end
          n = 3'd1;
        end
      end

      PH_DATA: begin
        if (req_type == REQ_DATA) begin
          // Drop words before the range, then deliver bytes
          if (skip_r != '0) begin
            skip_nxt = skip_r - 8'd1;
          end else if (odd_r) begin
            odd_nxt = 1'b0;
            if (bytes_left_r != '0) begin
              res[n]         = mk_result(ACT_BYTE, REG_DATA, data_word[15:8]);
              n              = n + 3'd1;
              bytes_left_nxt = bytes_left_r - 17'd1;
            end
          end else if (bytes_left_r >= 17'd2) begin
            res[n]         = mk_result(ACT_BYTE, REG_DATA, data_word[7:0]);
            n              = n + 3'd1;
            res[n]         = mk_result(ACT_BYTE, REG_DATA, data_word[15:8]);
            n              = n + 3'd1;
            bytes_left_nxt = bytes_left_r - 17'd2;
          end else if (bytes_left_r == 17'd1) begin
            res[n]         = mk_result(ACT_BYTE, REG_DATA, data_word[7:0]);
            n              = n + 3'd1;
            bytes_left_nxt = '0;
          end

          // Advance the word count: finish, poll at a sector edge, or read on
          word_index_nxt = wi_inc;
          if (wi_inc >= total_words_r) begin
            res[n]    = mk_result(ACT_DONE, REG_DATA, 8'd0);
            phase_nxt = PH_IDLE;
          end else if (wi_inc[SECTOR_WORD_BITS-1:0] == '0) begin
            res[n]    = mk_result(ACT_STAT, REG_CMD, 8'd0);
            phase_nxt = PH_POLL;
          end else begin
            res[n]    = mk_result(ACT_DATA, REG_DATA, 8'd0);
          end
          n = n + 3'd1;
        end
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // Mark the final result of this beat
    if (n != '0) begin
      res[n - 3'd1].last = 1'b1;
    end
    res_cnt = n;
  end

  // Commit state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      skip_r        <= '0;
      odd_r         <= 1'b0;
      bytes_left_r  <= '0;
      word_index_r  <= '0;
      total_words_r <= '0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      skip_r        <= skip_nxt;
      odd_r         <= odd_nxt;
      bytes_left_r  <= bytes_left_nxt;
      word_index_r  <= word_index_nxt;
      total_words_r <= total_words_nxt;
    end
  end

endmodule

>>> hdl/atapr_checker.sv
// ----------------------------------------------------------------------------
// atapr_checker
// Port-level checks for the ATA PIO byte range read sequencer.
// ----------------------------------------------------------------------------
module atapr_checker
  import atapr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic [31:0] in_byte_address,
  input logic [16:0] in_byte_length,
  input logic [7:0]  in_status_value,
  input logic [15:0] in_data_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_action,
  input logic [2:0]  out_reg_offset,
  input logic [7:0]  out_value,
  input logic        out_run_last
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // No new input beat is taken in the middle of a result run
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input taken while a result run is still pending");

  // Done and error always close their run
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_DONE || out_action == ACT_ERR) |-> out_run_last)
    else $error("done or error result not marked last");

endmodule

bind ata_pio_byte_range_read_core atapr_checker u_atapr_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ATA PIO byte range read sequencer.
// Drives start, status and data beats through a valid/ready port and checks
// every result beat against an in-bench model of the taskfile sequence, the
// status polling and the byte extraction. Stimulus mixes directed corners
// with random read transactions, stray beats and randomized stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import atapr_pkg::*;

  localparam int          CYCLE_LIMIT   = 40000;
  localparam int          WORDS_PER_SEC = 1 << SECTOR_WORD_BITS;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam logic [2:0]  NO_REG        = 3'd0;
  localparam int          LENGTH_MAX    = 130560;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] addr;
    logic [16:0] len;
    logic [7:0]  status;
    logic [15:0] word;
    bit          hold_for_idle;
  } pio_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_byte_address = '0;
  logic [16:0] in_byte_length = '0;
  logic [7:0]  in_status_value = '0;
  logic [15:0] in_data_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_action;
  logic [2:0]  out_reg_offset;
  logic [7:0]  out_value;
  logic        out_run_last;

  ata_pio_byte_range_read_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_byte_address (in_byte_address),
    .in_byte_length  (in_byte_length),
    .in_status_value (in_status_value),
    .in_data_word    (in_data_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action      (out_action),
    .out_reg_offset  (out_reg_offset),
    .out_value       (out_value),
    .out_run_last    (out_run_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pio_item_t pending_requests[$];
  result_t   results_due[$];
  pio_item_t cur_item;

  // Sequencer state as seen by the bench
  phase_t      seq_phase = PH_IDLE;
  logic [7:0]  skip_left = '0;
  logic        odd_lead = 1'b0;
  logic [16:0] bytes_todo = '0;
  logic [15:0] words_done = '0;
  logic [15:0] words_total = '0;

  int fail_count = 0;
  int in_beats = 0;
  int out_beats = 0;
  int reads_done = 0;
  int errors_flagged = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit stall_armed = 1'b1;
  logic steady_stretch;

  // No idling on either side over this window of input beats
  assign steady_stretch = (in_beats >= 120) && (in_beats < 200);

  // Sectors touched by a byte range, zero for an empty range; no 32-bit wrap
  function automatic int unsigned sector_span(logic [31:0] addr, logic [16:0] len);
    longint unsigned first_byte;
    longint unsigned last_byte;
    if (len == 0) return 0;
    first_byte = addr;
    last_byte  = first_byte + len - 1;
    return int'((last_byte >> SECTOR_BYTE_BITS) - (first_byte >> SECTOR_BYTE_BITS) + 1);
  endfunction

  function automatic void add_due(action_t act, logic [2:0] ofs, logic [7:0] val);
    result_t r;
    r.action     = act;
    r.reg_offset = ofs;
    r.value      = val;
    r.last       = 1'b0;
    results_due.push_back(r);
  endfunction

  // Work out the result beats of one accepted input beat and advance the state
  function automatic void predict_sequencer(pio_item_t it);
    int unsigned span;
    logic [22:0] lba;
    int          n_before;
    n_before = results_due.size();
    if (it.req == REQ_START && seq_phase == PH_IDLE) begin
      span = sector_span(it.addr, it.len);
      if (span == 0 || span > MAX_SECTORS) begin
        add_due(ACT_ERR, NO_REG, 8'h00);
        errors_flagged++;
      end else begin
        lba         = it.addr[31:SECTOR_BYTE_BITS];
        skip_left   = it.addr[8:1];
        odd_lead    = it.addr[0];
        bytes_todo  = it.len;
        words_done  = '0;
        words_total = 16'(span * WORDS_PER_SEC);
        add_due(ACT_REGW, REG_DRIVE, DRIVE_LBA_SEL | {4'h0, LBA_TOP_MASK & 4'(lba >> 24)});
        add_due(ACT_REGW, REG_COUNT, 8'(span));
        add_due(ACT_REGW, REG_LBA_LO, lba[7:0]);
        add_due(ACT_REGW, REG_LBA_MID, lba[15:8]);
        add_due(ACT_REGW, REG_LBA_HI, 8'(lba >> 16));
        add_due(ACT_REGW, REG_CMD, CMD_READ_PIO);
        add_due(ACT_STAT, REG_CMD, 8'h00);
        seq_phase = PH_POLL;
      end
    end else if (it.req == REQ_STATUS && seq_phase == PH_POLL) begin
      if (it.status[ST_ERR] || it.status[ST_DF]) begin
        add_due(ACT_ERR, NO_REG, 8'h00);
        errors_flagged++;
        seq_phase = PH_IDLE;
      end else if (it.status[ST_BSY]) begin
        add_due(ACT_STAT, REG_CMD, 8'h00);
      end else begin
        add_due(ACT_DATA, REG_DATA, 8'h00);
        seq_phase = PH_DATA;
      end
    end else if (it.req == REQ_DATA && seq_phase == PH_DATA) begin
      // Drop leading words, then split the rest into bytes
      if (skip_left != 0) begin
        skip_left--;
      end else if (odd_lead) begin
        odd_lead = 1'b0;
        if (bytes_todo != 0) begin
          add_due(ACT_BYTE, NO_REG, it.word[15:8]);
          bytes_todo--;
        end
      end else if (bytes_todo >= 2) begin
        add_due(ACT_BYTE, NO_REG, it.word[7:0]);
        add_due(ACT_BYTE, NO_REG, it.word[15:8]);
        bytes_todo -= 2;
      end else if (bytes_todo == 1) begin
        add_due(ACT_BYTE, NO_REG, it.word[7:0]);
        bytes_todo = '0;
      end
      words_done++;
      if (words_done >= words_total) begin
        add_due(ACT_DONE, NO_REG, 8'h00);
        reads_done++;
        seq_phase = PH_IDLE;
      end else if (words_done[SECTOR_WORD_BITS-1:0] == '0) begin
        add_due(ACT_STAT, REG_CMD, 8'h00);
        seq_phase = PH_POLL;
      end else begin
        add_due(ACT_DATA, REG_DATA, 8'h00);
      end
    end
    if (results_due.size() > n_before) results_due[results_due.size()-1].last = 1'b1;
  endfunction

  task automatic queue_item(logic [1:0] req, logic [31:0] addr, logic [16:0] len,
                            logic [7:0] status, logic [15:0] word, bit hold_for_idle);
    pio_item_t it;
    it.req           = req;
    it.addr          = addr;
    it.len           = len;
    it.status        = status;
    it.word          = word;
    it.hold_for_idle = hold_for_idle;
    pending_requests.push_back(it);
  endtask

  // Occasionally slip in a beat the sequencer must ignore in this phase
  task automatic add_noise(phase_t ph);
    logic [1:0] kind;
    if ($urandom_range(0, 99) < 6) begin
      do begin
        kind = 2'($urandom_range(0, 3));
      end while ((ph == PH_IDLE && kind == REQ_START) ||
                 (ph == PH_POLL && kind == REQ_STATUS) ||
                 (ph == PH_DATA && kind == REQ_DATA));
      queue_item(kind, $urandom, 17'($urandom_range(0, LENGTH_MAX)),
                 8'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  // One read transaction: start, polls with busy retries, sector words
  task automatic queue_read(logic [31:0] addr, logic [16:0] len, bit hold_for_idle,
                            int abort_pct);
    int unsigned span;
    int          busy_n;
    logic [7:0]  st;
    queue_item(REQ_START, addr, len, 8'($urandom), 16'($urandom), hold_for_idle);
    span = sector_span(addr, len);
    if (span == 0 || span > MAX_SECTORS) begin
      add_noise(PH_IDLE);
      return;
    end
    for (int s = 0; s < span; s++) begin
      busy_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (busy_n) begin
        st = 8'($urandom);
        st[ST_BSY] = 1'b1;
        st[ST_DF]  = 1'b0;
        st[ST_ERR] = 1'b0;
        queue_item(REQ_STATUS, $urandom, 17'($urandom), st, 16'($urandom), 1'b0);
        add_noise(PH_POLL);
      end
      st = 8'($urandom);
      if ($urandom_range(0, 99) < abort_pct) begin
        if (!st[ST_DF] && !st[ST_ERR]) st[($urandom_range(0, 1) != 0) ? ST_DF : ST_ERR] = 1'b1;
        queue_item(REQ_STATUS, $urandom, 17'($urandom), st, 16'($urandom), 1'b0);
        add_noise(PH_IDLE);
        return;
      end
      st[ST_BSY] = 1'b0;
      st[ST_DF]  = 1'b0;
      st[ST_ERR] = 1'b0;
      queue_item(REQ_STATUS, $urandom, 17'($urandom), st, 16'($urandom), 1'b0);
      for (int w = 0; w < WORDS_PER_SEC; w++) begin
        add_noise(PH_DATA);
        queue_item(REQ_DATA, $urandom, 17'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      end
    end
    add_noise(PH_IDLE);
  endtask

  // Driver: present one beat at a time, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sequencer(cur_item);
        in_beats <= in_beats + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 &&
            (steady_stretch || $urandom_range(0, 99) >= 36) &&
            !(pending_requests[0].hold_for_idle && results_due.size() != 0)) begin
          cur_item = pending_requests.pop_front();
          in_valid        <= 1'b1;
          in_req_type     <= cur_item.req;
          in_byte_address <= cur_item.addr;
          in_byte_length  <= cur_item.len;
          in_status_value <= cur_item.status;
          in_data_word    <= cur_item.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, so the result buffer fills and stalls the input
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left  <= 0;
      stall_armed <= 1'b1;
    end else if (stall_armed && in_beats >= 60) begin
      stall_left  <= 400;
      stall_armed <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_beats <= out_beats + 1;
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result: action %0d reg %0d value %02h last %0b",
                     $time, out_action, out_reg_offset, out_value, out_run_last);
        end else begin
          due = results_due.pop_front();
          if (out_action !== due.action || out_reg_offset !== due.reg_offset ||
              out_value !== due.value || out_run_last !== due.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: exp action %0d reg %0d value %02h last %0b, %s",
                       $time, due.action, due.reg_offset, due.value, due.last,
                       $sformatf("got action %0d reg %0d value %02h last %0b",
                                 out_action, out_reg_offset, out_value, out_run_last));
          end
        end
      end
      out_ready <= (stall_left == 0) && (steady_stretch || $urandom_range(0, 99) >= 36);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] a;
    logic [16:0] l;
    logic [8:0]  lead;

    // Directed: stray beats, bad spans, widest span, busy and error status
    queue_item(REQ_DATA, 32'h0, 17'h0, 8'h00, 16'hFFFF, 1'b0);
    queue_item(REQ_STATUS, 32'h0, 17'h0, 8'hFF, 16'h0000, 1'b0);
    queue_item(REQ_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 16'hFFFF, 1'b0);
    queue_item(REQ_START, 32'h0000_0000, 17'd0, 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_START, 32'hFFFF_FFFF, 17'(LENGTH_MAX), 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_START, 32'hFFFF_FE00, 17'(LENGTH_MAX), 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_START, 32'h0000_0000, 17'd1, 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_DATA, 32'h0, 17'h0, 8'h00, 16'h1234, 1'b0);
    queue_item(REQ_UNUSED, 32'h0, 17'h0, 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_STATUS, 32'h0, 17'h0, 8'h80, 16'h0000, 1'b0);
    queue_item(REQ_STATUS, 32'h0, 17'h0, 8'hFE, 16'h0000, 1'b0);
    queue_item(REQ_START, 32'h0000_0003, 17'd1, 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_STATUS, 32'h0, 17'h0, 8'h81, 16'h0000, 1'b0);
    queue_item(REQ_START, 32'h0012_3457, 17'd3, 8'h00, 16'h0000, 1'b0);
    queue_item(REQ_STATUS, 32'h0, 17'h0, 8'h20, 16'h0000, 1'b0);

    // Random reads cut short by a failing status
    for (int t = 0; t < 4; t++) begin
      a = $urandom;
      l = 17'($urandom_range(1, 2048));
      queue_read(a, l, (t == 0), 100);
    end

    // Spans the sequencer refuses: empty, and one sector too many
    queue_read({23'($urandom), 9'h1FF}, 17'd0, 1'b0, 0);
    queue_read({23'($urandom), 9'h1FF}, 17'($urandom_range(130050, LENGTH_MAX)), 1'b0, 0);

    // One full sector: skipped words, odd lead byte, odd tail byte, drain to the end
    lead = 9'(2 * $urandom_range(4, 40) + 1);
    a    = {23'($urandom), lead};
    l    = 17'(2 * $urandom_range(20, 100));
    queue_read(a, l, 1'b1, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every beat is in and every result has come back
    while (pending_requests.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (results_due.size() != 0) begin
      fail_count += results_due.size();
      $display("%0d expected results never arrived", results_due.size());
    end

    $display("Covered %0d input beats and %0d result beats: %0d reads ran to done,",
             in_beats, out_beats, reads_done);
    $display("%0d error results from bad spans and failing status", errors_flagged);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/atapr_pkg.sv
hdl/atapr_step.sv
hdl/ata_pio_byte_range_read_core.sv
hdl/atapr_checker.sv
test/testbench.sv
